>>> sv/bspq_pkg.sv
`timescale 1ns / 1ps

package bspq_pkg;

   // Queue geometry and field widths.
   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;
   localparam int CNT_W  = 5;
   localparam int KIND_W = 2;
   localparam int STAT_W = 2;

   // Capacity limit after reset.
   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   // Operation codes.
   localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

   // Status codes.
   localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_POP_EMPTY = 2'd2;

   // One held pair.
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
   } entry_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic      push;
      logic      pop;
      entry_type new_entry;
   } cmd_type;

endpackage

>>> sv/bspq_cell.sv
`timescale 1ns / 1ps

module bspq_cell (
   input  logic                clock,
   input  bspq_pkg::cmd_type   cmd,
   input  logic                occupied,
   input  logic                left_keep,
   input  bspq_pkg::entry_type left_entry,
   input  bspq_pkg::entry_type right_entry,
   output logic                keep,
   output bspq_pkg::entry_type entry,
   output bspq_pkg::entry_type entry_next
);

   bspq_pkg::entry_type entry_ff;
   bspq_pkg::entry_type entry_in;

   // The held pair stays in place when its priority is equal or higher than the new one.
   assign keep = occupied && ($signed(entry_ff.prio) >= $signed(cmd.new_entry.prio));

   // A push either keeps this pair, takes the new pair, or takes the left neighbor's.
   // A pop takes the right neighbor's pair.
   always_comb begin
      entry_in = entry_ff;
      if (cmd.push) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (left_keep) begin
            entry_in = cmd.new_entry;
         end else begin
            entry_in = left_entry;
         end
      end else if (cmd.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

>>> sv/bounded_stable_priority_queue_core.sv
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// -------   ------------------------  -------------------------------------------------
// request   start, busy               req_kind, req_new_value, req_new_priority
// response  rsp_valid (strobe)        rsp_head_value, rsp_head_priority, rsp_item_count,
//                                     rsp_is_empty, rsp_is_full, rsp_status
// csr       csr_valid, csr_ready      csr_data (capacity limit)
//
// One transaction is accepted in every cycle; busy stays low.
// The response strobes for one cycle, in the cycle after the request is accepted.
// Every cell of the row compares its own priority with the new one in the same cycle
// and shifts its pair by one place, whatever the state of the queue.
// Synchronous reset empties the queue and restores the capacity limit to 16.
// The receiver cannot stall, so responses are never held back.
module bounded_stable_priority_queue_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [bspq_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [bspq_pkg::DATA_W-1:0]  req_new_value,
   input  logic signed [bspq_pkg::DATA_W-1:0]  req_new_priority,
   output logic                                rsp_valid,
   output logic signed [bspq_pkg::DATA_W-1:0]  rsp_head_value,
   output logic signed [bspq_pkg::DATA_W-1:0]  rsp_head_priority,
   output logic [bspq_pkg::CNT_W-1:0]          rsp_item_count,
   output logic                                rsp_is_empty,
   output logic                                rsp_is_full,
   output logic [bspq_pkg::STAT_W-1:0]         rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bspq_pkg::CNT_W-1:0]          csr_data
);

   logic                            accept;
   logic [bspq_pkg::CNT_W-1:0]      capacity_ff;
   logic [bspq_pkg::CNT_W-1:0]      limit;
   logic [bspq_pkg::CNT_W-1:0]      count_ff;
   logic [bspq_pkg::CNT_W-1:0]      count_in;
   logic                            push_ok;
   logic                            pop_ok;
   logic [bspq_pkg::STAT_W-1:0]     status;
   bspq_pkg::cmd_type               cmd;
   bspq_pkg::entry_type             head;

   logic                            rsp_valid_ff;
   bspq_pkg::entry_type             rsp_head_ff;
   logic [bspq_pkg::CNT_W-1:0]      rsp_count_ff;
   logic                            rsp_empty_ff;
   logic                            rsp_full_ff;
   logic [bspq_pkg::STAT_W-1:0]     rsp_status_ff;

   logic                            keep       [bspq_pkg::DEPTH];
   bspq_pkg::entry_type             entry      [bspq_pkg::DEPTH];
   bspq_pkg::entry_type             entry_next [bspq_pkg::DEPTH];

   // The queue never stalls a transaction, and the limit may be written at any time.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // Capacity limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= bspq_pkg::CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_data;
      end
   end

   assign limit = (capacity_ff < bspq_pkg::DEPTH_CNT) ? capacity_ff : bspq_pkg::DEPTH_CNT;

   // Decode the operation and work out the status and the new count.
   always_comb begin
      push_ok  = 1'b0;
      pop_ok   = 1'b0;
      status   = bspq_pkg::STATUS_OK;
      count_in = count_ff;
      if (accept) begin
         unique case (req_kind)
            bspq_pkg::KIND_PUSH: begin
               if (count_ff >= limit) begin
                  status = bspq_pkg::STATUS_FULL;
               end else begin
                  push_ok  = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            bspq_pkg::KIND_POP: begin
               if (count_ff == '0) begin
                  status = bspq_pkg::STATUS_POP_EMPTY;
               end else begin
                  pop_ok   = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
            default: begin
               status = bspq_pkg::STATUS_OK;
            end
         endcase
      end
   end

   assign cmd.push            = push_ok;
   assign cmd.pop             = pop_ok;
   assign cmd.new_entry.value = req_new_value;
   assign cmd.new_entry.prio  = req_new_priority;

   // Row of cells, head at cell zero.
   for (genvar i = 0; i < bspq_pkg::DEPTH; i++) begin : g_cell
      logic                occupied;
      logic                left_keep;
      bspq_pkg::entry_type left_entry;
      bspq_pkg::entry_type right_entry;

      assign occupied = count_ff > bspq_pkg::CNT_W'(i);

      if (i == 0) begin : g_first
         assign left_keep  = 1'b1;
         assign left_entry = cmd.new_entry;
      end else begin : g_inner
         assign left_keep  = keep[i-1];
         assign left_entry = entry[i-1];
      end

      if (i == bspq_pkg::DEPTH - 1) begin : g_last
         assign right_entry = entry[i];
      end else begin : g_body
         assign right_entry = entry[i+1];
      end

      bspq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (occupied),
         .left_keep   (left_keep),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .keep        (keep[i]),
         .entry       (entry[i]),
         .entry_next  (entry_next[i])
      );
   end

   // A pop reports the pair it removes; otherwise the head after the step, or zero.
   always_comb begin
      if (pop_ok) begin
         head = entry[0];
      end else if (count_in != '0) begin
         head = entry_next[0];
      end else begin
         head = '0;
      end
   end

   // Count and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_head_ff   <= head;
         rsp_count_ff  <= count_in;
         rsp_empty_ff  <= (count_in == '0);
         rsp_full_ff   <= (count_in >= limit);
         rsp_status_ff <= status;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_head_value    = rsp_head_ff.value;
   assign rsp_head_priority = rsp_head_ff.prio;
   assign rsp_item_count    = rsp_count_ff;
   assign rsp_is_empty      = rsp_empty_ff;
   assign rsp_is_full       = rsp_full_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

>>> bench/bounded_stable_priority_queue_core_tb.sv
`timescale 1ns / 1ps

module bounded_stable_priority_queue_core_tb;

   // The fourth operation code has no name in the package and acts as status only.
   localparam logic [bspq_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

   // Cycles allowed with no transaction of any kind before the run is declared hung.
   localparam int STALL_LIMIT = 5000;
   // Quiet cycles before a capacity write and after the last response.
   localparam int SETTLE_CYCLES = 3;

   // One planned transaction: either an operation or a capacity write.
   typedef struct {
      bit                                  is_cap_write;
      bit                                  no_gap;
      logic [bspq_pkg::KIND_W-1:0]         kind;
      logic signed [bspq_pkg::DATA_W-1:0]  value;
      logic signed [bspq_pkg::DATA_W-1:0]  prio;
      logic [bspq_pkg::CNT_W-1:0]          cap;
   } op_slot_type;

   // One response as the block reports it.
   typedef struct packed {
      logic signed [bspq_pkg::DATA_W-1:0]  head_value;
      logic signed [bspq_pkg::DATA_W-1:0]  head_priority;
      logic [bspq_pkg::CNT_W-1:0]          item_count;
      logic                                is_empty;
      logic                                is_full;
      logic [bspq_pkg::STAT_W-1:0]         status;
   } head_report_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic [bspq_pkg::KIND_W-1:0]         req_kind = bspq_pkg::KIND_STATUS;
   logic signed [bspq_pkg::DATA_W-1:0]  req_new_value = '0;
   logic signed [bspq_pkg::DATA_W-1:0]  req_new_priority = '0;
   logic                                rsp_valid;
   logic signed [bspq_pkg::DATA_W-1:0]  rsp_head_value;
   logic signed [bspq_pkg::DATA_W-1:0]  rsp_head_priority;
   logic [bspq_pkg::CNT_W-1:0]          rsp_item_count;
   logic                                rsp_is_empty;
   logic                                rsp_is_full;
   logic [bspq_pkg::STAT_W-1:0]         rsp_status;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [bspq_pkg::CNT_W-1:0]          csr_data = '0;

   // Planned transactions, and responses still owed by the block.
   op_slot_type      op_plan[$];
   head_report_type  expected_reports[$];

   // Shadow copy of the sorted queue and its capacity register.
   logic signed [bspq_pkg::DATA_W-1:0]  held_value[bspq_pkg::DEPTH];
   logic signed [bspq_pkg::DATA_W-1:0]  held_prio[bspq_pkg::DEPTH];
   int                                  held_count = 0;
   logic [bspq_pkg::CNT_W-1:0]          cap_limit = bspq_pkg::CAP_RESET;

   int  error_count = 0;
   int  settle_cnt = 0;
   int  stall_cnt = 0;

   bounded_stable_priority_queue_core dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_new_value     (req_new_value),
      .req_new_priority  (req_new_priority),
      .rsp_valid         (rsp_valid),
      .rsp_head_value    (rsp_head_value),
      .rsp_head_priority (rsp_head_priority),
      .rsp_item_count    (rsp_item_count),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   // Clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      error_count++;
   endtask

   // Applies one operation to the shadow queue and queues the response it owes.
   task automatic sorted_queue_step(input logic [bspq_pkg::KIND_W-1:0] kind,
                                    input logic signed [bspq_pkg::DATA_W-1:0] val,
                                    input logic signed [bspq_pkg::DATA_W-1:0] pri);
      head_report_type  rpt;
      int               lim;
      int               pos;
      int               i;
      bit               popped;
      lim = (int'(cap_limit) < bspq_pkg::DEPTH) ? int'(cap_limit) : bspq_pkg::DEPTH;
      rpt = '0;
      rpt.status = bspq_pkg::STATUS_OK;
      popped = 1'b0;
      if (kind == bspq_pkg::KIND_PUSH) begin
         if (held_count >= lim) begin
            rpt.status = bspq_pkg::STATUS_FULL;
         end else begin
            // The new pair goes behind every entry of equal or higher priority.
            pos = 0;
            while (pos < held_count && !(held_prio[pos] < pri)) pos++;
            for (i = held_count; i > pos; i--) begin
               held_value[i] = held_value[i-1];
               held_prio[i]  = held_prio[i-1];
            end
            held_value[pos] = val;
            held_prio[pos]  = pri;
            held_count++;
         end
      end else if (kind == bspq_pkg::KIND_POP) begin
         if (held_count == 0) begin
            rpt.status = bspq_pkg::STATUS_POP_EMPTY;
         end else begin
            rpt.head_value    = held_value[0];
            rpt.head_priority = held_prio[0];
            popped = 1'b1;
            for (i = 1; i < held_count; i++) begin
               held_value[i-1] = held_value[i];
               held_prio[i-1]  = held_prio[i];
            end
            held_count--;
         end
      end
      // Any other operation reports the head without touching the queue.
      if (!popped && held_count > 0) begin
         rpt.head_value    = held_value[0];
         rpt.head_priority = held_prio[0];
      end
      rpt.item_count = bspq_pkg::CNT_W'(held_count);
      rpt.is_empty   = (held_count == 0);
      rpt.is_full    = (held_count >= lim);
      expected_reports.push_back(rpt);
   endtask

   function automatic void plan_op(input logic [bspq_pkg::KIND_W-1:0] kind,
                                   input logic signed [bspq_pkg::DATA_W-1:0] val,
                                   input logic signed [bspq_pkg::DATA_W-1:0] pri,
                                   input bit no_gap);
      op_slot_type s;
      s.is_cap_write = 1'b0;
      s.no_gap = no_gap;
      s.kind = kind;
      s.value = val;
      s.prio = pri;
      s.cap = '0;
      op_plan.push_back(s);
   endfunction

   function automatic void plan_cap(input logic [bspq_pkg::CNT_W-1:0] cap);
      op_slot_type s;
      s.is_cap_write = 1'b1;
      s.no_gap = 1'b0;
      s.kind = bspq_pkg::KIND_STATUS;
      s.value = '0;
      s.prio = '0;
      s.cap = cap;
      op_plan.push_back(s);
   endfunction

   // Priorities lean toward a few small values so that ties are common.
   function automatic logic signed [bspq_pkg::DATA_W-1:0] pick_priority();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(6)) - 3;
         2: begin
            case ($urandom_range(3))
               0: return 32'sh8000_0000;
               1: return 32'sh7fff_ffff;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         default: return $urandom_range(2);
      endcase
   endfunction

   // Driver: retires transactions taken at this edge and presents the next one.
   always @(posedge clock) begin
      logic         nxt_start;
      logic         nxt_csr;
      op_slot_type  head;
      if (reset) begin
         start     <= 1'b0;
         csr_valid <= 1'b0;
         settle_cnt = 0;
      end else begin
         nxt_start = start;
         nxt_csr   = csr_valid;
         if (start && !busy) begin
            sorted_queue_step(req_kind, req_new_value, req_new_priority);
            void'(op_plan.pop_front());
            nxt_start = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            cap_limit = csr_data;
            void'(op_plan.pop_front());
            nxt_csr = 1'b0;
         end
         if (!nxt_start && !nxt_csr && op_plan.size() > 0) begin
            head = op_plan[0];
            if (head.is_cap_write) begin
               // The capacity register is only written once the block has gone quiet.
               if (expected_reports.size() != 0) begin
                  settle_cnt = 0;
               end else if (settle_cnt >= SETTLE_CYCLES) begin
                  settle_cnt = 0;
                  nxt_csr = 1'b1;
                  csr_data <= head.cap;
               end else begin
                  settle_cnt++;
               end
            end else if (head.no_gap || $urandom_range(99) >= 29) begin
               nxt_start = 1'b1;
               req_kind         <= head.kind;
               req_new_value    <= head.value;
               req_new_priority <= head.prio;
            end
         end
         start     <= nxt_start;
         csr_valid <= nxt_csr;
      end
   end

   // Monitor: every strobed response is checked against the oldest expectation.
   always @(posedge clock) begin
      head_report_type want;
      head_report_type got;
      if (!reset && rsp_valid) begin
         got = '{rsp_head_value, rsp_head_priority, rsp_item_count,
                 rsp_is_empty, rsp_is_full, rsp_status};
         if (expected_reports.size() == 0) begin
            report_mismatch("response with no transaction waiting");
         end else begin
            want = expected_reports.pop_front();
            if (got.head_value !== want.head_value)
               report_mismatch($sformatf("head_value %0d, expected %0d",
                                         got.head_value, want.head_value));
            if (got.head_priority !== want.head_priority)
               report_mismatch($sformatf("head_priority %0d, expected %0d",
                                         got.head_priority, want.head_priority));
            if (got.item_count !== want.item_count)
               report_mismatch($sformatf("item_count %0d, expected %0d",
                                         got.item_count, want.item_count));
            if (got.is_empty !== want.is_empty)
               report_mismatch($sformatf("is_empty %0b, expected %0b",
                                         got.is_empty, want.is_empty));
            if (got.is_full !== want.is_full)
               report_mismatch($sformatf("is_full %0b, expected %0b",
                                         got.is_full, want.is_full));
            if (got.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         got.status, want.status));
         end
      end
   end

   // Watchdog: ends the run when no transaction of any kind moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cnt = 0;
      end else begin
         stall_cnt++;
         if (stall_cnt >= STALL_LIMIT) begin
            $display("watchdog expired with %0d transactions planned, %0d responses owed",
                     op_plan.size(), expected_reports.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Stimulus plan, reset and end of run.
   initial begin
      logic [bspq_pkg::CNT_W-1:0]   phase_caps[12];
      int                           push_pct;
      int                           r;
      logic [bspq_pkg::KIND_W-1:0]  k;

      // Directed: empty queue, every operation, extreme fields and a priority tie.
      plan_op(bspq_pkg::KIND_STATUS, 32'sd5, 32'sd5, 1'b0);
      plan_op(bspq_pkg::KIND_POP, 32'sd0, 32'sd0, 1'b0);
      plan_op(KIND_UNUSED, -32'sd1, -32'sd1, 1'b0);
      plan_op(bspq_pkg::KIND_PUSH, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
      plan_op(bspq_pkg::KIND_PUSH, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
      plan_op(bspq_pkg::KIND_PUSH, 32'sd1, 32'sd0, 1'b0);
      plan_op(bspq_pkg::KIND_PUSH, 32'sd2, 32'sd0, 1'b0);
      plan_op(bspq_pkg::KIND_PUSH, -32'sd1, -32'sd1, 1'b0);
      plan_op(bspq_pkg::KIND_STATUS, 32'sd0, 32'sd0, 1'b0);
      plan_op(bspq_pkg::KIND_POP, 32'sd0, 32'sd0, 1'b0);
      plan_op(bspq_pkg::KIND_POP, 32'sd0, 32'sd0, 1'b0);
      plan_op(bspq_pkg::KIND_POP, 32'sd0, 32'sd0, 1'b0);
      plan_op(bspq_pkg::KIND_POP, 32'sd0, 32'sd0, 1'b0);
      plan_op(bspq_pkg::KIND_POP, 32'sd0, 32'sd0, 1'b0);
      // A zero limit refuses a push on an empty queue.
      plan_cap(5'd0);
      plan_op(bspq_pkg::KIND_PUSH, 32'sd9, 32'sd9, 1'b0);
      plan_op(bspq_pkg::KIND_POP, 32'sd0, 32'sd0, 1'b0);
      // Fill a small limit, then lower it below the held count.
      plan_cap(5'd2);
      plan_op(bspq_pkg::KIND_PUSH, 32'sd10, 32'sd3, 1'b0);
      plan_op(bspq_pkg::KIND_PUSH, 32'sd11, 32'sd3, 1'b0);
      plan_op(bspq_pkg::KIND_PUSH, 32'sd12, 32'sd4, 1'b0);
      plan_cap(5'd1);
      plan_op(bspq_pkg::KIND_STATUS, 32'sd0, 32'sd0, 1'b0);
      plan_op(bspq_pkg::KIND_POP, 32'sd0, 32'sd0, 1'b0);
      plan_op(bspq_pkg::KIND_POP, 32'sd0, 32'sd0, 1'b0);

      // Random phases, each under its own limit; one phase runs with no gaps.
      phase_caps = '{5'd31, 5'd16, 5'd0, 5'd1, 5'd15, 5'd16,
                     5'd2, 5'd8, 5'd17, 5'd3, 5'd16, 5'd5};
      for (int ph = 0; ph < 12; ph++) begin
         plan_cap((ph % 3 == 2) ? bspq_pkg::CNT_W'($urandom) : phase_caps[ph]);
         case ($urandom_range(2))
            0: push_pct = 30;
            1: push_pct = 50;
            default: push_pct = 70;
         endcase
         for (int n = 0; n < 150; n++) begin
            r = $urandom_range(99);
            if (r < push_pct) k = bspq_pkg::KIND_PUSH;
            else if (r < 95) k = bspq_pkg::KIND_POP;
            else if (r < 98) k = bspq_pkg::KIND_STATUS;
            else k = KIND_UNUSED;
            plan_op(k, $urandom, pick_priority(), ph == 5);
         end
      end
      // Leave the register back at its full-depth setting.
      plan_cap(bspq_pkg::CAP_RESET);
      plan_op(bspq_pkg::KIND_STATUS, 32'sd0, 32'sd0, 1'b0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (op_plan.size() != 0 || expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES + 2) @(posedge clock);

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/bspq_pkg.sv
sv/bspq_cell.sv
sv/bounded_stable_priority_queue_core.sv
bench/bounded_stable_priority_queue_core_tb.sv
